@@ hdl/j5s_pkg.sv @@
// shared types and constants for the five-point jacobi sweep
package j5s_pkg;

	localparam int SAMPLE_W   = 48;
	localparam int VALUE_W    = 64;
	localparam int COORD_W    = 12;
	localparam int HSQ_W      = 39;
	localparam int INV_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 39;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_INNER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SQUARED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_SQ  = 2'd2;

	localparam logic [COORD_W-1:0] GRID_INNER_RST = 12'd1022;
	localparam logic [HSQ_W-1:0]   STEP_SQ_RST    = 39'd1048576;
	localparam logic [INV_W-1:0]   INV_STEP_RST   = 24'd1046529;

	localparam logic        KIND_POINT = 1'b0;
	localparam logic        KIND_SUM   = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_READ = 14'b00000000000010,
		S_NB   = 14'b00000000000100,
		S_ND   = 14'b00000000001000,
		S_M0   = 14'b00000000010000,
		S_M1   = 14'b00000000100000,
		S_P    = 14'b00000001000000,
		S_T    = 14'b00000010000000,
		S_Q0   = 14'b00000100000000,
		S_Q1   = 14'b00001000000000,
		S_Q2   = 14'b00010000000000,
		S_Q3   = 14'b00100000000000,
		S_Q4   = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

endpackage

@@ hdl/j5s_grid_if.sv @@
// grid sample channel
interface j5s_grid_if;
	import j5s_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                frame_start;
	modport source (output valid, output sample, output frame_start, input ready);
	modport sink (input valid, input sample, input frame_start, output ready);
endinterface

@@ hdl/j5s_result_if.sv @@
// result channel
interface j5s_result_if;
	import j5s_pkg::*;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [VALUE_W-1:0] value;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	modport source (output valid, output kind, output value, output row, output column,
		input ready);
	modport sink (input valid, input kind, input value, input row, input column,
		output ready);
endinterface

@@ hdl/jacobi_5pt_stencil_sweep_top.sv @@
// one jacobi sweep of the five-point stencil with residual norm squared
//
// The grid streams in raster order, ghost border included, one sample per beat.
// Each beat is handled on its own: a border sample or a beat that closes no
// stencil goes through the line store read, then write back; the last grid
// position also passes the result register, as it carries the residual sum;
// an inner point also runs the arithmetic steps on the single shared 32x32
// multiplier, forming the residual product in two partial products and its
// square in three, followed by the result register. A beat that reaches the
// result register while the previous result still waits holds there until
// the receiver takes it. The two line stores are single synchronous memories
// of MAX_INNER+2 entries, read at the beat's acceptance and written back in the
// following cycle, so no two beats ever overlap on the same entry. The result
// register lets the next beat enter while a finished result waits. The residual
// sum comes out as its own beat at the last grid position. Line stores start
// undefined; a stream that begins with frame_start needs no clearing pass.
module jacobi_5pt_stencil_sweep_top #(
	parameter int MAX_INNER = 1022,
	parameter int FRAC_BITS = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [j5s_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [j5s_pkg::CFG_DATA_W-1:0] cfg_data,
	j5s_grid_if.sink                       grid,
	j5s_result_if.source                   result
);
	import j5s_pkg::*;

	localparam int STORE_DEPTH = MAX_INNER + 2;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic signed [VALUE_W-1:0] I64_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] I64_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] Q_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] Q_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [VALUE_W:0] ONE = (VALUE_W+1)'(1) << FRAC_BITS;

	// configuration
	logic [COORD_W-1:0] grid_inner_q;
	logic [HSQ_W-1:0]   hsq_q;
	logic [INV_W-1:0]   inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_inner_q <= GRID_INNER_RST;
			hsq_q        <= STEP_SQ_RST;
			inv_q        <= INV_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_INNER:   grid_inner_q <= cfg_data[COORD_W-1:0];
				REG_STEP_SQUARED: hsq_q        <= cfg_data[HSQ_W-1:0];
				REG_INV_STEP_SQ:  inv_q        <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped grid size
	logic [COORD_W-1:0] n;
	always_comb begin
		if (grid_inner_q == '0)
			n = COORD_W'(1);
		else if (grid_inner_q > COORD_W'(MAX_INNER))
			n = COORD_W'(MAX_INNER);
		else
			n = grid_inner_q;
	end

	state_t state_q;
	logic accept;
	assign grid.ready = (state_q == S_IDLE);
	assign accept = grid.valid && grid.ready;

	// position of the incoming beat
	logic [COORD_W-1:0] row_q, col_q, r_eff, c_eff;
	logic [COORD_W:0]   n_p1, c_p1;
	logic border, compute, row_end, frame_end, top_ok, right_ok;
	always_comb begin
		r_eff     = grid.frame_start ? '0 : row_q;
		c_eff     = grid.frame_start ? '0 : col_q;
		n_p1      = {1'b0, n} + 1'b1;
		c_p1      = {1'b0, c_eff} + 1'b1;
		border    = (r_eff == '0) || ({1'b0, r_eff} >= n_p1) ||
			(c_eff == '0) || ({1'b0, c_eff} >= n_p1);
		compute   = (c_eff != '0) && (r_eff >= COORD_W'(2)) &&
			({1'b0, r_eff} <= n_p1) && (c_eff <= n);
		row_end   = ({1'b0, c_eff} >= n_p1);
		frame_end = row_end && ({1'b0, r_eff} >= n_p1);
		top_ok    = (32'(c_eff) < STORE_DEPTH);
		right_ok  = (32'(c_p1) < STORE_DEPTH) && (c_eff < n);
	end

	// line stores
	logic [SAMPLE_W-1:0] older_mem [STORE_DEPTH];
	logic [SAMPLE_W-1:0] prev_mem  [STORE_DEPTH];
	logic [SAMPLE_W-1:0] older_rd_q, prev_rd_q, prev_rd1_q;
	logic [AW-1:0]       addr_q;
	logic                store_ok_q, top_ok_q, right_ok_q, compute_q, emit_sum_q;
	sample_t             s_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			older_rd_q <= older_mem[c_eff[AW-1:0]];
			prev_rd_q  <= prev_mem[c_eff[AW-1:0]];
			prev_rd1_q <= prev_mem[c_p1[AW-1:0]];
		end
		if (state_q == S_READ && store_ok_q) begin
			older_mem[addr_q] <= prev_rd_q;
			prev_mem[addr_q]  <= s_q;
		end
	end

	// datapath registers
	sample_t top_q, right_q, left_q, cen_q;
	sample_t win0_q, win1_q, right_now;
	logic signed [SAMPLE_W+1:0] nb_q;
	sample_t nv_q;
	logic [SAMPLE_W+2:0] mag_q;
	logic                neg_q;
	logic [63:0]         mul_q, lo_q;
	logic [31:0]         mul_a, mul_b;
	logic signed [VALUE_W-1:0] p_q;
	logic [VALUE_W-1:0]  tmag_q;
	logic [127:0]        acc_q;
	logic [VALUE_W-1:0]  sum_q;
	logic [VALUE_W-1:0]  res_val_q;
	logic [COORD_W-1:0]  res_row_q, res_col_q;
	logic                out_valid_q, out_kind_q;
	logic [VALUE_W-1:0]  out_val_q;
	logic [COORD_W-1:0]  out_row_q, out_col_q;

	assign right_now = right_ok_q ? sample_t'(prev_rd1_q) : '0;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_M0: begin
				mul_a = mag_q[31:0];
				mul_b = 32'(inv_q);
			end
			S_M1: begin
				mul_a = 32'(mag_q[SAMPLE_W+2:32]);
				mul_b = 32'(inv_q);
			end
			S_Q0: begin
				mul_a = tmag_q[31:0];
				mul_b = tmag_q[31:0];
			end
			S_Q1: begin
				mul_a = tmag_q[63:32];
				mul_b = tmag_q[31:0];
			end
			S_Q2: begin
				mul_a = tmag_q[63:32];
				mul_b = tmag_q[63:32];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// arithmetic steps
	logic signed [SAMPLE_W+2:0] nv_sum, d_val;
	logic signed [SAMPLE_W:0]   nv_quarter;
	logic signed [SAMPLE_W+1:0] four_cen;
	logic [95:0]                m_full;
	logic [VALUE_W:0]           t_diff;
	logic signed [VALUE_W-1:0]  t_val;
	logic [127:0]               sq_shift;
	logic [VALUE_W-1:0]         sq_val;
	logic [VALUE_W:0]           sum_next;
	always_comb begin
		nv_sum     = $signed({12'b0, hsq_q}) + (SAMPLE_W+3)'(nb_q);
		nv_quarter = nv_sum[SAMPLE_W+2:2];
		four_cen   = {cen_q, 2'b00};
		d_val      = (SAMPLE_W+3)'(four_cen) - (SAMPLE_W+3)'(nb_q);
		m_full     = {mul_q, 32'b0} + {32'b0, lo_q};
		t_diff     = {p_q[VALUE_W-1], p_q} - ONE;
		t_val      = (t_diff[VALUE_W:VALUE_W-1] == 2'b10) ? I64_MIN : t_diff[VALUE_W-1:0];
		sq_shift   = acc_q >> FRAC_BITS;
		sq_val     = (|sq_shift[127:VALUE_W-1]) ? I64_MAX : {1'b0, sq_shift[VALUE_W-2:0]};
		sum_next   = {1'b0, sum_q} + {1'b0, sq_val};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_READ: begin
				top_q   <= top_ok_q ? sample_t'(older_rd_q) : '0;
				right_q <= right_now;
				left_q  <= win0_q;
				cen_q   <= win1_q;
			end
			S_NB: nb_q <= (SAMPLE_W+2)'(top_q) + (SAMPLE_W+2)'(s_q) +
				(SAMPLE_W+2)'(left_q) + (SAMPLE_W+2)'(right_q);
			S_ND: begin
				if (nv_quarter[SAMPLE_W] != nv_quarter[SAMPLE_W-1])
					nv_q <= nv_quarter[SAMPLE_W] ? Q_MIN : Q_MAX;
				else
					nv_q <= nv_quarter[SAMPLE_W-1:0];
				neg_q <= d_val[SAMPLE_W+2];
				mag_q <= d_val[SAMPLE_W+2] ? (SAMPLE_W+3)'(-d_val) : d_val;
			end
			S_M1: lo_q <= mul_q;
			S_P: begin
				// product beyond the signed 64-bit range saturates
				if (|m_full[95:VALUE_W-1])
					p_q <= neg_q ? I64_MIN : I64_MAX;
				else
					p_q <= neg_q ? -$signed(m_full[63:0]) : $signed(m_full[63:0]);
			end
			S_T: tmag_q <= t_val[VALUE_W-1] ? VALUE_W'(-t_val) : t_val;
			S_Q1: acc_q <= {64'b0, mul_q};
			S_Q2: acc_q <= acc_q + ({64'b0, mul_q} << 33);
			S_Q3: acc_q <= acc_q + {mul_q, 64'b0};
			S_Q4: res_val_q <= VALUE_W'(nv_q);
			default: ;
		endcase
		if (accept) begin
			addr_q     <= c_eff[AW-1:0];
			store_ok_q <= top_ok;
			top_ok_q   <= top_ok;
			right_ok_q <= right_ok;
			compute_q  <= compute;
			emit_sum_q <= frame_end;
			s_q        <= border ? '0 : sample_t'(grid.sample);
			res_row_q  <= r_eff - COORD_W'(2);
			res_col_q  <= c_eff - COORD_W'(1);
			if (frame_end)
				res_val_q <= sum_q;
		end
	end

	// control: sequencer, counters, window, sum, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			win0_q      <= '0;
			win1_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
						if (grid.frame_start || frame_end)
							sum_q <= '0;
						if (row_end) begin
							col_q <= '0;
							row_q <= frame_end ? '0 : r_eff + COORD_W'(1);
						end else begin
							col_q <= c_eff + COORD_W'(1);
							row_q <= r_eff;
						end
					end
				end
				S_READ: begin
					if (addr_q == '0 && !top_ok_q) begin
						win0_q <= win1_q;
						win1_q <= right_now;
					end else if (res_col_q == '1) begin
						// column zero restarts the window
						win0_q <= '0;
						win1_q <= right_now;
					end else begin
						win0_q <= win1_q;
						win1_q <= right_now;
					end
					if (compute_q)
						state_q <= S_NB;
					else if (emit_sum_q)
						state_q <= S_OUT;
					else
						state_q <= S_IDLE;
				end
				S_NB: state_q <= S_ND;
				S_ND: state_q <= S_M0;
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_P;
				S_P:  state_q <= S_T;
				S_T:  state_q <= S_Q0;
				S_Q0: state_q <= S_Q1;
				S_Q1: state_q <= S_Q2;
				S_Q2: state_q <= S_Q3;
				S_Q3: state_q <= S_Q4;
				S_Q4: begin
					sum_q   <= sum_next[VALUE_W-1] ? I64_MAX : sum_next[VALUE_W-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || result.ready)) begin
			out_kind_q <= emit_sum_q ? KIND_SUM : KIND_POINT;
			out_val_q  <= res_val_q;
			out_row_q  <= emit_sum_q ? '0 : res_row_q;
			out_col_q  <= emit_sum_q ? '0 : res_col_q;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.kind   = out_kind_q;
	assign result.value  = out_val_q;
	assign result.row    = out_row_q;
	assign result.column = out_col_q;

	// saturating sum of squares never turns negative
	a_sum_nonneg: assert property (@(posedge clk) disable iff (!arst_n) !sum_q[VALUE_W-1])
		else $error("residual sum went negative");

	// an accepted beat always goes to the line store read
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_READ)
		else $error("accepted beat skipped the store read");

	// the result register only loads from the output step
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output step");

	// an inner point's column lies inside the grid
	a_point_col: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == KIND_POINT) |-> result.column < COORD_W'(MAX_INNER))
		else $error("point column beyond the grid");

endmodule
